// ===== hw/rtl/wrd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wrd_pkg: shared types and constants
// Widths, controller states and command/status structures for the weighted
// radial distance block.
// ----------------------------------------------------------------------------
package wrd_pkg;

  localparam int CoordBits  = 12;
  localparam int GrayBits   = 16;
  localparam int CenterBits = 16;
  localparam int ThrBits    = 16;
  localparam int SumBits    = 56;
  localparam int TotalBits  = 32;
  localparam int CorrBits   = 21;
  // Squared distance in Q.8 needs at most 35 bits; root is 18 bits.
  localparam int SqBits     = 36;
  localparam int RootBits   = SqBits / 2;
  localparam int ProdBits   = RootBits + GrayBits;
  localparam int DivBits    = SumBits + 4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_ACC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture the pixel and start the root
    logic acc;       // accumulate product and weight
    logic div_start; // load the divider
    logic clear;     // end of run: load the result, reset accumulators
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/wrd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wrd_in_if / wrd_out_if / wrd_cfg_if: channel interfaces
// Valid/ready channels carrying pixels, results and the threshold.
// ----------------------------------------------------------------------------
interface wrd_in_if;
  logic                             valid;
  logic                             ready;
  logic [wrd_pkg::CoordBits-1:0]    pixel_x;
  logic [wrd_pkg::CoordBits-1:0]    pixel_y;
  logic [wrd_pkg::GrayBits-1:0]     gray;
  logic [wrd_pkg::CenterBits-1:0]   center_x;
  logic [wrd_pkg::CenterBits-1:0]   center_y;
  logic                             last;
  modport source (output valid, pixel_x, pixel_y, gray, center_x, center_y, last,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, gray, center_x, center_y, last,
                output ready);
endinterface

interface wrd_out_if;
  logic                           valid;
  logic                           ready;
  logic [wrd_pkg::CorrBits-1:0]   correlation;
  logic                           empty_res;
  modport source (output valid, correlation, empty_res, input ready);
  modport sink (input valid, correlation, empty_res, output ready);
endinterface

interface wrd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wrd_pkg::ThrBits-1:0]   data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/weighted_radial_distance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_radial_distance: weighted mean radial distance of an object
// Per pixel: accept, root, accumulate; the next pixel is taken only after that.
// Last pixel: the divider runs, then the result register loads and out_valid rises.
// A waiting result stalls the input only once a second result is ready behind it.
// Reset (rst_n low, synchronous) clears threshold, accumulators and run state.
// ----------------------------------------------------------------------------
module weighted_radial_distance (
  input wire logic clk,
  input wire logic rst_n,
  wrd_in_if.sink   in_ch,
  wrd_out_if.source out_ch,
  wrd_cfg_if.sink  cfg_ch
);

  wrd_pkg::cmd_t  cmd;
  wrd_pkg::stat_t stat;
  logic [wrd_pkg::ThrBits-1:0] thr_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else if (cfg_ch.valid) begin
      thr_r <= cfg_ch.data;
    end
  end

  wrd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.last),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  wrd_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .pixel_x     (in_ch.pixel_x),
    .pixel_y     (in_ch.pixel_y),
    .gray        (in_ch.gray),
    .center_x    (in_ch.center_x),
    .center_y    (in_ch.center_y),
    .threshold   (thr_r),
    .correlation (out_ch.correlation),
    .empty_res   (out_ch.empty_res)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/wrd_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wrd_datapath: arithmetic of the weighted radial distance block
// Bit-serial square root (one result bit per cycle), multiply-accumulate with
// saturation, a restoring divider (one quotient bit per cycle) and the result
// register.
// ----------------------------------------------------------------------------
module wrd_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire wrd_pkg::cmd_t                  cmd,
  output wrd_pkg::stat_t                      stat,
  input  wire logic [wrd_pkg::CoordBits-1:0]  pixel_x,
  input  wire logic [wrd_pkg::CoordBits-1:0]  pixel_y,
  input  wire logic [wrd_pkg::GrayBits-1:0]   gray,
  input  wire logic [wrd_pkg::CenterBits-1:0] center_x,
  input  wire logic [wrd_pkg::CenterBits-1:0] center_y,
  input  wire logic [wrd_pkg::ThrBits-1:0]    threshold,
  output logic [wrd_pkg::CorrBits-1:0]        correlation,
  output logic                                empty_res
);

  localparam int SqBits   = wrd_pkg::SqBits;
  localparam int RootBits = wrd_pkg::RootBits;
  localparam int DivBits  = wrd_pkg::DivBits;
  localparam int TotBits  = wrd_pkg::TotalBits;
  localparam int SumBits  = wrd_pkg::SumBits;
  localparam int CntBits  = $clog2(DivBits + 1);
  localparam logic [SumBits-1:0] SumMax = '1;
  localparam logic [TotBits-1:0] TotMax = '1;

  logic                          inside_r, inside_nxt;
  logic [wrd_pkg::CenterBits-1:0] hcx_r, hcy_r;
  logic [SumBits-1:0]            sum_r, sum_nxt;
  logic [TotBits-1:0]            tot_r, tot_nxt;
  logic [wrd_pkg::GrayBits-1:0]  w_r;
  logic [SqBits-1:0]             rem_r;
  logic [RootBits-1:0]           root_r;
  logic [CntBits-1:0]            cnt_r;
  logic [DivBits-1:0]            num_r;
  logic [TotBits:0]              drem_r;
  logic [DivBits-1:0]            quo_r;
  logic [wrd_pkg::CorrBits-1:0]  corr_r, corr_nxt;
  logic                          empty_r, empty_nxt;

  // Squared distance of the pixel to the centre in use.
  logic [wrd_pkg::CenterBits-1:0] cx, cy;
  logic [16:0] px4, py4, dx, dy;
  logic [33:0] dx2, dy2;
  logic [SqBits-1:0] sq;
  logic [16:0] wd;

  always_comb begin
    cx  = inside_r ? hcx_r : center_x;
    cy  = inside_r ? hcy_r : center_y;
    px4 = {1'b0, pixel_x, 4'b0};
    py4 = {1'b0, pixel_y, 4'b0};
    dx  = (px4 >= {1'b0, cx}) ? px4 - {1'b0, cx} : {1'b0, cx} - px4;
    dy  = (py4 >= {1'b0, cy}) ? py4 - {1'b0, cy} : {1'b0, cy} - py4;
    dx2 = dx * dx;
    dy2 = dy * dy;
    sq  = {2'b0, dx2} + {2'b0, dy2};
    wd  = {1'b0, gray} - {1'b0, threshold};
  end

  // Digit-by-digit root: one bit per cycle, MSB first.
  logic [RootBits+1:0] trial;
  always_comb begin
    trial = {root_r, 2'b01};
  end

  // Root remainder window: bits of the radicand enter two at a time.
  logic [RootBits+1:0] rwin;
  logic [SqBits-1:0]   rad_r;
  logic                sqrt_busy_r, div_busy_r;
  always_comb begin
    rwin = {rem_r[RootBits-1:0], rad_r[SqBits-1 -: 2]};
  end

  logic [wrd_pkg::ProdBits-1:0] prod_w;
  logic [SumBits-1:0]           prod;
  always_comb begin
    prod_w  = root_r * w_r;
    prod    = SumBits'(prod_w);
    sum_nxt = (prod > SumMax - sum_r) ? SumMax : sum_r + prod;
    tot_nxt = (TotBits'(w_r) > TotMax - tot_r) ? TotMax : tot_r + TotBits'(w_r);
    inside_nxt = inside_r;
    if (cmd.load) inside_nxt = 1'b1;
    if (cmd.clear) inside_nxt = 1'b0;
  end

  logic [TotBits:0] dtry;
  always_comb begin
    dtry = {drem_r[TotBits-1:0], num_r[DivBits-1]};
  end

  assign stat.sqrt_done = sqrt_busy_r && (cnt_r == '0);
  assign stat.div_done  = div_busy_r && (cnt_r == '0);

  // Saturated quotient, or the empty flag when no weight was seen.
  always_comb begin
    empty_nxt = (tot_r == '0);
    if (empty_nxt) begin
      corr_nxt = '0;
    end else if (quo_r[DivBits-1:wrd_pkg::CorrBits] != '0) begin
      corr_nxt = '1;
    end else begin
      corr_nxt = quo_r[wrd_pkg::CorrBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r    <= 1'b0;
      sum_r       <= '0;
      tot_r       <= '0;
      hcx_r       <= '0;
      hcy_r       <= '0;
      cnt_r       <= '0;
      sqrt_busy_r <= 1'b0;
      div_busy_r  <= 1'b0;
      corr_r      <= '0;
      empty_r     <= 1'b0;
    end else begin
      inside_r <= inside_nxt;
      if (cmd.load) begin
        if (!inside_r) begin
          hcx_r <= center_x;
          hcy_r <= center_y;
        end
        w_r         <= wd[16] ? '0 : wd[15:0];
        rad_r       <= sq;
        rem_r       <= '0;
        root_r      <= '0;
        cnt_r       <= CntBits'(RootBits);
        sqrt_busy_r <= 1'b1;
      end else if (sqrt_busy_r && cnt_r != '0) begin
        rad_r <= rad_r << 2;
        cnt_r <= cnt_r - 1'b1;
        if (rwin >= trial) begin
          rem_r  <= SqBits'(rwin - trial);
          root_r <= {root_r[RootBits-2:0], 1'b1};
        end else begin
          rem_r  <= SqBits'(rwin);
          root_r <= {root_r[RootBits-2:0], 1'b0};
        end
      end else if (sqrt_busy_r) begin
        sqrt_busy_r <= 1'b0;
      end
      if (cmd.acc) begin
        sum_r <= sum_nxt;
        tot_r <= tot_nxt;
      end
      // The last pixel is accumulated in the same cycle, so its sum is taken.
      if (cmd.div_start) begin
        num_r      <= {sum_nxt, 4'b0};
        drem_r     <= '0;
        quo_r      <= '0;
        cnt_r      <= CntBits'(DivBits);
        div_busy_r <= 1'b1;
      end else if (div_busy_r && cnt_r != '0) begin
        num_r <= num_r << 1;
        cnt_r <= cnt_r - 1'b1;
        if (dtry >= {1'b0, tot_r}) begin
          drem_r <= dtry - {1'b0, tot_r};
          quo_r  <= {quo_r[DivBits-2:0], 1'b1};
        end else begin
          drem_r <= dtry;
          quo_r  <= {quo_r[DivBits-2:0], 1'b0};
        end
      end else if (div_busy_r) begin
        div_busy_r <= 1'b0;
      end
      if (cmd.clear) begin
        sum_r   <= '0;
        tot_r   <= '0;
        corr_r  <= corr_nxt;
        empty_r <= empty_nxt;
      end
    end
  end

  assign correlation = corr_r;
  assign empty_res   = empty_r;

`ifndef SYNTHESIS
  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sqrt_busy_r && div_busy_r)) else $error("root and divider both busy");
  a_tot_sat: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.acc && !cmd.clear && $past(rst_n) |=> tot_r >= $past(tot_r))
    else $error("weight total decreased during accumulation");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> !inside_r && tot_r == '0) else $error("run not cleared");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/wrd_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wrd_ctrl: sequencing controller
// Accepts a pixel, waits for the root, accumulates, and on the last pixel
// runs the divider and loads the result register once it is free.
// ----------------------------------------------------------------------------
module wrd_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic           in_last,
  output logic                out_valid,
  input  wire logic           out_ready,
  output wrd_pkg::cmd_t       cmd,
  input  wire wrd_pkg::stat_t stat
);

  wrd_pkg::state_t state_r, state_nxt;
  logic            last_r, last_nxt;
  logic            ovalid_r, ovalid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= wrd_pkg::ST_IDLE;
      last_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      last_r   <= last_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    ovalid_nxt = ovalid_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      wrd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          last_nxt  = in_last;
          state_nxt = wrd_pkg::ST_SQRT;
        end
      end
      wrd_pkg::ST_SQRT: begin
        if (stat.sqrt_done) state_nxt = wrd_pkg::ST_ACC;
      end
      wrd_pkg::ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = last_r ? wrd_pkg::ST_DIV : wrd_pkg::ST_IDLE;
      end
      wrd_pkg::ST_DIV: begin
        // Divider starts on entry; wait for its done.
        if (stat.div_done) state_nxt = wrd_pkg::ST_OUT;
      end
      wrd_pkg::ST_OUT: begin
        // The result register takes the new result once the old one is gone.
        if (!ovalid_r || out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = wrd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wrd_pkg::ST_IDLE;
    endcase
    if (state_r == wrd_pkg::ST_ACC && last_r) cmd.div_start = 1'b1;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    if (cmd.clear) ovalid_nxt = 1'b1;
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |-> (!out_valid || out_ready)) else $error("waiting result overwritten");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result withdrawn");
  a_div_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> last_r) else $error("divider started mid-run");
`endif

endmodule
`default_nettype wire
